// ===== sv/bpq_pkg.sv =====
// Package for the bounded priority queue: field widths, command and status
// codes, and the result type of the shared compare unit. No dependencies.
package bpq_pkg;

  // Default number of queue slots
  localparam int DEPTH_DEF = 16;

  // Field widths
  localparam int CMD_W     = 2;
  localparam int ID_W      = 16;
  localparam int PRI_W     = 8;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ROTATE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Flags from the shared compare unit
  typedef struct packed {
    logic pri_gt;  // x priority above y priority
    logic id_eq;   // x id equals y id
  } cmp_res_t;

endpackage

// ===== sv/bpq_store.sv =====
// Slot storage for the bounded priority queue: id and priority arrays with
// one write port and one registered read port. Depends on bpq_pkg.
module bpq_store #(
  parameter int DEPTH = bpq_pkg::DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [bpq_pkg::ID_W-1:0]  wid,
  input  logic [bpq_pkg::PRI_W-1:0] wpri,
  input  logic [AW-1:0]             raddr,
  output logic [bpq_pkg::ID_W-1:0]  rid,
  output logic [bpq_pkg::PRI_W-1:0] rpri
);
  import bpq_pkg::*;

  logic [ID_W-1:0]  mem_id  [DEPTH];
  logic [PRI_W-1:0] mem_pri [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_id[waddr]  <= wid;
      mem_pri[waddr] <= wpri;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rid  <= mem_id[raddr];
    rpri <= mem_pri[raddr];
  end

endmodule

// ===== sv/bpq_cmp.sv =====
// Shared compare unit of the bounded priority queue: priority magnitude and
// id equality on operands chosen by the sequencer. Depends on bpq_pkg.
module bpq_cmp (
  input  logic [bpq_pkg::PRI_W-1:0] x_pri,
  input  logic [bpq_pkg::PRI_W-1:0] y_pri,
  input  logic [bpq_pkg::ID_W-1:0]  x_id,
  input  logic [bpq_pkg::ID_W-1:0]  y_id,
  output bpq_pkg::cmp_res_t         res
);
  import bpq_pkg::*;

  always_comb begin
    res.pri_gt = (x_pri > y_pri);
    res.id_eq  = (x_id == y_id);
  end

endmodule

// ===== sv/bounded_priority_queue_unit.sv =====
// Bounded priority queue: ordered list of up to DEPTH (id, priority) entries.
// Depends on bpq_pkg, bpq_store and bpq_cmp.
//
// Usage:
//   A request (in_cmd, in_entry_id, in_entry_priority) is taken at a rising
//   edge with start high and busy low. Commands: insert, pop head, rotate
//   head to tail, remove first entry with a matching id.
//   Exactly one result follows per request, shown for one cycle with
//   out_valid high; busy stays high from the request until that cycle ends.
//   The receiver cannot stall, so the result is lost if not sampled then.
// Operation:
//   Entries live in a single-port-read slot memory; one sequencer walks it
//   with one read and one write per cycle. Pop, rotate and remove shift the
//   tail down one slot per cycle; insert may first scan for its place, then
//   shift the tail up. The next request can be taken the cycle after the strobe.
// Reset:
//   rst_n low empties the queue (count zero) and returns to idle. Slot
//   contents are not cleared; only slots below the count are ever read.
module bounded_priority_queue_unit #(
  parameter int DEPTH = bpq_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bpq_pkg::CMD_W-1:0]     in_cmd,
  input  logic [bpq_pkg::ID_W-1:0]      in_entry_id,
  input  logic [bpq_pkg::PRI_W-1:0]     in_entry_priority,
  output logic                          out_valid,
  output logic [bpq_pkg::ST_W-1:0]      out_status,
  output logic [bpq_pkg::ID_W-1:0]      out_popped_id,
  output logic [bpq_pkg::PRI_W-1:0]     out_popped_priority,
  output logic                          out_head_valid,
  output logic [bpq_pkg::ID_W-1:0]      out_head_id,
  output logic [bpq_pkg::PRI_W-1:0]     out_head_priority,
  output logic [bpq_pkg::CNT_OUT_W-1:0] out_entry_count
);
  import bpq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TAIL_RD,
    S_TAIL_CHK,
    S_SCAN,
    S_SHIFT,
    S_FINAL,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Latched request
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [PRI_W-1:0] pri_r, pri_nxt;

  // Queue bookkeeping and head mirror of slot 0
  logic [CW-1:0]    count_r, count_nxt;
  logic [ID_W-1:0]  head_id_r, head_id_nxt;
  logic [PRI_W-1:0] head_pri_r, head_pri_nxt;

  // Result fields
  logic [ST_W-1:0]  status_r, status_nxt;
  logic [ID_W-1:0]  pop_id_r, pop_id_nxt;
  logic [PRI_W-1:0] pop_pri_r, pop_pri_nxt;

  // Scan walker
  logic [CW-1:0] sc_rd_r, sc_rd_nxt;
  logic          sc_pend_r, sc_pend_nxt;
  logic [AW-1:0] sc_addr_r, sc_addr_nxt;

  // Shift walker
  logic [AW-1:0] sh_rd_r, sh_rd_nxt;
  logic [CW-1:0] sh_left_r, sh_left_nxt;
  logic          sh_up_r, sh_up_nxt;
  logic          sh_pend_r, sh_pend_nxt;
  logic [AW-1:0] sh_dst_r, sh_dst_nxt;

  // Closing write in the final state, after any shift
  logic             fin_en_r, fin_en_nxt;
  logic [AW-1:0]    fin_addr_r, fin_addr_nxt;
  logic [ID_W-1:0]  fin_id_r, fin_id_nxt;
  logic [PRI_W-1:0] fin_pri_r, fin_pri_nxt;

  // Memory and compare unit hookup
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [ID_W-1:0]  wid, rd_id;
  logic [PRI_W-1:0] wpri, rd_pri;
  logic [PRI_W-1:0] x_pri, y_pri;
  cmp_res_t         cmp;
  logic             match;

  bpq_store #(.DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wid   (wid),
    .wpri  (wpri),
    .raddr (raddr),
    .rid   (rd_id),
    .rpri  (rd_pri)
  );

  bpq_cmp u_cmp (
    .x_pri (x_pri),
    .y_pri (y_pri),
    .x_id  (rd_id),
    .y_id  (id_r),
    .res   (cmp)
  );

  // Scan hit: insert stops at first priority at or below its own
  assign match = (cmd_r == CMD_INSERT) ? !cmp.pri_gt : cmp.id_eq;

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    id_nxt       = id_r;
    pri_nxt      = pri_r;
    count_nxt    = count_r;
    head_id_nxt  = head_id_r;
    head_pri_nxt = head_pri_r;
    status_nxt   = status_r;
    pop_id_nxt   = pop_id_r;
    pop_pri_nxt  = pop_pri_r;
    sc_rd_nxt    = sc_rd_r;
    sc_pend_nxt  = sc_pend_r;
    sc_addr_nxt  = sc_addr_r;
    sh_rd_nxt    = sh_rd_r;
    sh_left_nxt  = sh_left_r;
    sh_up_nxt    = sh_up_r;
    sh_pend_nxt  = sh_pend_r;
    sh_dst_nxt   = sh_dst_r;
    fin_en_nxt   = fin_en_r;
    fin_addr_nxt = fin_addr_r;
    fin_id_nxt   = fin_id_r;
    fin_pri_nxt  = fin_pri_r;
    we           = 1'b0;
    waddr        = '0;
    wid          = rd_id;
    wpri         = rd_pri;
    raddr        = '0;
    x_pri        = pri_r;
    y_pri        = head_pri_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt     = in_cmd;
          id_nxt      = in_entry_id;
          pri_nxt     = in_entry_priority;
          status_nxt  = ST_DONE;
          pop_id_nxt  = '0;
          pop_pri_nxt = '0;
          fin_en_nxt  = 1'b0;
          sh_pend_nxt = 1'b0;
          sc_pend_nxt = 1'b0;
          state_nxt   = S_DECODE;
        end
      end

      S_DECODE: begin
        case (cmd_r)
          CMD_INSERT: begin
            if (count_r == CW'(DEPTH)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else if (count_r == '0) begin
              fin_en_nxt   = 1'b1;
              fin_addr_nxt = '0;
              fin_id_nxt   = id_r;
              fin_pri_nxt  = pri_r;
              count_nxt    = count_r + CW'(1);
              state_nxt    = S_FINAL;
            end else if (cmp.pri_gt) begin
              // new entry goes in front: move everything up
              sh_rd_nxt    = AW'(count_r - CW'(1));
              sh_left_nxt  = count_r;
              sh_up_nxt    = 1'b1;
              fin_en_nxt   = 1'b1;
              fin_addr_nxt = '0;
              fin_id_nxt   = id_r;
              fin_pri_nxt  = pri_r;
              count_nxt    = count_r + CW'(1);
              state_nxt    = S_SHIFT;
            end else begin
              state_nxt = S_TAIL_RD;
            end
          end
          CMD_POP: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              pop_id_nxt  = head_id_r;
              pop_pri_nxt = head_pri_r;
              sh_rd_nxt   = AW'(1);
              sh_left_nxt = count_r - CW'(1);
              sh_up_nxt   = 1'b0;
              count_nxt   = count_r - CW'(1);
              state_nxt   = S_SHIFT;
            end
          end
          CMD_ROTATE: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else if (count_r == CW'(1)) begin
              state_nxt = S_DONE;
            end else begin
              // old head lands in the last slot after the shift down
              fin_en_nxt   = 1'b1;
              fin_addr_nxt = AW'(count_r - CW'(1));
              fin_id_nxt   = head_id_r;
              fin_pri_nxt  = head_pri_r;
              sh_rd_nxt    = AW'(1);
              sh_left_nxt  = count_r - CW'(1);
              sh_up_nxt    = 1'b0;
              state_nxt    = S_SHIFT;
            end
          end
          default: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              sc_rd_nxt = '0;
              state_nxt = S_SCAN;
            end
          end
        endcase
      end

      S_TAIL_RD: begin
        raddr     = AW'(count_r - CW'(1));
        state_nxt = S_TAIL_CHK;
      end

      S_TAIL_CHK: begin
        y_pri = rd_pri;
        if (!cmp.pri_gt) begin
          // at or below the tail: append
          fin_en_nxt   = 1'b1;
          fin_addr_nxt = AW'(count_r);
          fin_id_nxt   = id_r;
          fin_pri_nxt  = pri_r;
          count_nxt    = count_r + CW'(1);
          state_nxt    = S_FINAL;
        end else begin
          sc_rd_nxt = CW'(1);
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        x_pri = rd_pri;
        y_pri = pri_r;
        if (sc_pend_r && match) begin
          sc_pend_nxt = 1'b0;
          if (cmd_r == CMD_INSERT) begin
            sh_rd_nxt    = AW'(count_r - CW'(1));
            sh_left_nxt  = count_r - CW'(sc_addr_r);
            sh_up_nxt    = 1'b1;
            fin_en_nxt   = 1'b1;
            fin_addr_nxt = sc_addr_r;
            fin_id_nxt   = id_r;
            fin_pri_nxt  = pri_r;
            count_nxt    = count_r + CW'(1);
          end else begin
            sh_rd_nxt   = sc_addr_r + AW'(1);
            sh_left_nxt = count_r - CW'(1) - CW'(sc_addr_r);
            sh_up_nxt   = 1'b0;
            count_nxt   = count_r - CW'(1);
          end
          state_nxt = S_SHIFT;
        end else if (sc_rd_r < count_r) begin
          raddr       = sc_rd_r[AW-1:0];
          sc_pend_nxt = 1'b1;
          sc_addr_nxt = sc_rd_r[AW-1:0];
          sc_rd_nxt   = sc_rd_r + CW'(1);
        end else begin
          sc_pend_nxt = 1'b0;
          if (!sc_pend_r) begin
            status_nxt = ST_EMPTY;
            state_nxt  = S_DONE;
          end
        end
      end

      S_SHIFT: begin
        // write back the slot read last cycle, one place over
        if (sh_pend_r) begin
          we    = 1'b1;
          waddr = sh_dst_r;
        end
        if (sh_left_r != '0) begin
          raddr       = sh_rd_r;
          sh_pend_nxt = 1'b1;
          sh_dst_nxt  = sh_up_r ? sh_rd_r + AW'(1) : sh_rd_r - AW'(1);
          sh_rd_nxt   = sh_up_r ? sh_rd_r - AW'(1) : sh_rd_r + AW'(1);
          sh_left_nxt = sh_left_r - CW'(1);
        end else begin
          sh_pend_nxt = 1'b0;
          if (!sh_pend_r) begin
            state_nxt = S_FINAL;
          end
        end
      end

      S_FINAL: begin
        if (fin_en_r) begin
          we    = 1'b1;
          waddr = fin_addr_r;
          wid   = fin_id_r;
          wpri  = fin_pri_r;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Keep the head mirror in step with slot 0
    if (we && (waddr == '0)) begin
      head_id_nxt  = wid;
      head_pri_nxt = wpri;
    end
  end

  // State and registered fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      sc_pend_r <= 1'b0;
      sh_pend_r <= 1'b0;
      fin_en_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      sc_pend_r <= sc_pend_nxt;
      sh_pend_r <= sh_pend_nxt;
      fin_en_r  <= fin_en_nxt;
    end
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    pri_r      <= pri_nxt;
    head_id_r  <= head_id_nxt;
    head_pri_r <= head_pri_nxt;
    status_r   <= status_nxt;
    pop_id_r   <= pop_id_nxt;
    pop_pri_r  <= pop_pri_nxt;
    sc_rd_r    <= sc_rd_nxt;
    sc_addr_r  <= sc_addr_nxt;
    sh_rd_r    <= sh_rd_nxt;
    sh_left_r  <= sh_left_nxt;
    sh_up_r    <= sh_up_nxt;
    sh_dst_r   <= sh_dst_nxt;
    fin_addr_r <= fin_addr_nxt;
    fin_id_r   <= fin_id_nxt;
    fin_pri_r  <= fin_pri_nxt;
  end

  // Ports
  assign busy                = (state_r != S_IDLE);
  assign out_valid           = (state_r == S_DONE);
  assign out_status          = status_r;
  assign out_popped_id       = pop_id_r;
  assign out_popped_priority = pop_pri_r;
  assign out_head_valid      = (count_r != '0);
  assign out_head_id         = out_head_valid ? head_id_r : '0;
  assign out_head_priority   = out_head_valid ? head_pri_r : '0;
  assign out_entry_count     = CNT_OUT_W'(count_r);

endmodule

// ===== sv/bpq_checker.sv =====
// Port-level checks for the bounded priority queue, bound to the top level.
// Depends on bpq_pkg and bounded_priority_queue_unit.
module bpq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [bpq_pkg::ST_W-1:0]      out_status,
  input logic [bpq_pkg::ID_W-1:0]      out_popped_id,
  input logic [bpq_pkg::PRI_W-1:0]     out_popped_priority,
  input logic                          out_head_valid,
  input logic [bpq_pkg::ID_W-1:0]      out_head_id,
  input logic [bpq_pkg::PRI_W-1:0]     out_head_priority
);
  import bpq_pkg::*;

  // A taken request keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request taken but block not busy");

  // The result strobe closes the request
  a_strobe_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid)
    else $error("block still busy after result");

  // A failed request reports zero popped fields
  a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_DONE) |->
      (out_popped_id == '0) && (out_popped_priority == '0))
    else $error("popped fields set on failed request");

  // A refused insert means the queue holds entries
  a_full_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_head_valid)
    else $error("full status with empty queue");

  // Empty queue shows a zero head
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_head_valid |->
      (out_head_id == '0) && (out_head_priority == '0))
    else $error("head fields set on empty queue");

endmodule

bind bounded_priority_queue_unit bpq_checker u_bpq_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for bounded_priority_queue_unit: directed and random
// queue requests, with a result predictor held in a small scoreboard class.
// Depends on bpq_pkg and the bounded_priority_queue_unit RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bpq_pkg::*;

  localparam int QDEPTH          = DEPTH_DEF;
  localparam int NUM_RANDOM_REQS = 2000;
  localparam int QUIET_LIMIT     = 1000;
  localparam int DRAIN_CYCLES    = 2 * QDEPTH + 16;
  localparam int MAX_PRINTED     = 100;

  // Request mixes for the random part
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} req_mix_t;

  // One result as the block reports it
  typedef struct {
    logic [ST_W-1:0]      status;
    logic [ID_W-1:0]      popped_id;
    logic [PRI_W-1:0]     popped_priority;
    logic                 head_valid;
    logic [ID_W-1:0]      head_id;
    logic [PRI_W-1:0]     head_priority;
    logic [CNT_OUT_W-1:0] entry_count;
  } queue_result_t;

  // Scoreboard: mirrors the queue contents and holds the results still owed
  class queue_scoreboard_t;
    logic [ID_W-1:0]  slot_id [QDEPTH];
    logic [PRI_W-1:0] slot_pri [QDEPTH];
    int               occupancy;
    queue_result_t    owed_results[$];
    int               errors;

    function new();
      occupancy = 0;
      errors    = 0;
    endfunction

    function int owed_count();
      return owed_results.size();
    endfunction

    // Drop slot pos, moving the later entries down one
    function void close_slot(int pos);
      for (int i = pos; i + 1 < occupancy; i++) begin
        slot_id[i]  = slot_id[i + 1];
        slot_pri[i] = slot_pri[i + 1];
      end
      occupancy--;
    endfunction

    // Work out the new queue contents and the result of one accepted request
    function void note_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                               logic [PRI_W-1:0] pri);
      queue_result_t    res;
      int               pos;
      logic [ID_W-1:0]  keep_id;
      logic [PRI_W-1:0] keep_pri;
      bit               found;
      res.status          = ST_DONE;
      res.popped_id       = '0;
      res.popped_priority = '0;
      case (cmd)
        CMD_INSERT: begin
          if (occupancy >= QDEPTH) begin
            res.status = ST_FULL;
          end else begin
            // Placement: empty, above head, at or below tail, else scan
            if (occupancy == 0 || pri > slot_pri[0]) begin
              pos = 0;
            end else if (pri <= slot_pri[occupancy - 1]) begin
              pos = occupancy;
            end else begin
              pos = 1;
              while (pos < occupancy && slot_pri[pos] > pri) pos++;
            end
            for (int i = occupancy; i > pos; i--) begin
              slot_id[i]  = slot_id[i - 1];
              slot_pri[i] = slot_pri[i - 1];
            end
            slot_id[pos]  = id;
            slot_pri[pos] = pri;
            occupancy++;
          end
        end
        CMD_POP: begin
          if (occupancy == 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.popped_id       = slot_id[0];
            res.popped_priority = slot_pri[0];
            close_slot(0);
          end
        end
        CMD_ROTATE: begin
          if (occupancy == 0) begin
            res.status = ST_EMPTY;
          end else if (occupancy >= 2) begin
            keep_id  = slot_id[0];
            keep_pri = slot_pri[0];
            close_slot(0);
            slot_id[occupancy]  = keep_id;
            slot_pri[occupancy] = keep_pri;
            occupancy++;
          end
        end
        default: begin
          // Remove the first entry with a matching id
          found = 1'b0;
          for (int i = 0; i < occupancy && !found; i++) begin
            if (slot_id[i] == id) begin
              close_slot(i);
              found = 1'b1;
            end
          end
          if (!found) res.status = ST_EMPTY;
        end
      endcase
      res.head_valid    = (occupancy > 0);
      res.head_id       = (occupancy > 0) ? slot_id[0] : '0;
      res.head_priority = (occupancy > 0) ? slot_pri[0] : '0;
      res.entry_count   = CNT_OUT_W'(occupancy);
      owed_results.push_back(res);
    endfunction

    task report_mismatch(string what, int got, int want);
      if (errors < MAX_PRINTED)
        $display("%0t MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      errors++;
    endtask

    // Compare one strobed result with the oldest owed result
    task check_result(queue_result_t got);
      queue_result_t want;
      if (owed_results.size() == 0) begin
        report_mismatch("result with no request outstanding", got.entry_count, 0);
      end else begin
        want = owed_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
        if (got.popped_id !== want.popped_id)
          report_mismatch("popped_id", got.popped_id, want.popped_id);
        if (got.popped_priority !== want.popped_priority)
          report_mismatch("popped_priority", got.popped_priority, want.popped_priority);
        if (got.head_valid !== want.head_valid)
          report_mismatch("head_valid", got.head_valid, want.head_valid);
        if (got.head_id !== want.head_id)
          report_mismatch("head_id", got.head_id, want.head_id);
        if (got.head_priority !== want.head_priority)
          report_mismatch("head_priority", got.head_priority, want.head_priority);
        if (got.entry_count !== want.entry_count)
          report_mismatch("entry_count", got.entry_count, want.entry_count);
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [CMD_W-1:0]     in_cmd;
  logic [ID_W-1:0]      in_entry_id;
  logic [PRI_W-1:0]     in_entry_priority;
  logic                 out_valid;
  logic [ST_W-1:0]      out_status;
  logic [ID_W-1:0]      out_popped_id;
  logic [PRI_W-1:0]     out_popped_priority;
  logic                 out_head_valid;
  logic [ID_W-1:0]      out_head_id;
  logic [PRI_W-1:0]     out_head_priority;
  logic [CNT_OUT_W-1:0] out_entry_count;

  queue_scoreboard_t sb;
  int                quiet_cycles;

  bounded_priority_queue_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_cmd              (in_cmd),
    .in_entry_id         (in_entry_id),
    .in_entry_priority   (in_entry_priority),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_popped_id       (out_popped_id),
    .out_popped_priority (out_popped_priority),
    .out_head_valid      (out_head_valid),
    .out_head_id         (out_head_id),
    .out_head_priority   (out_head_priority),
    .out_entry_count     (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: results are checked before a request at the same edge is noted
  always @(posedge clk) begin
    queue_result_t got;
    if (rst_n) begin
      if (out_valid) begin
        got.status          = out_status;
        got.popped_id       = out_popped_id;
        got.popped_priority = out_popped_priority;
        got.head_valid      = out_head_valid;
        got.head_id         = out_head_id;
        got.head_priority   = out_head_priority;
        got.entry_count     = out_entry_count;
        sb.check_result(got);
      end
      if (start && !busy) sb.note_request(in_cmd, in_entry_id, in_entry_priority);
    end
  end

  // Watchdog on cycles with neither a request nor a result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t timeout: no request or result for %0d cycles", $realtime, QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request and hold it until accepted
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                              logic [PRI_W-1:0] pri);
    start             <= 1'b1;
    in_cmd            <= cmd;
    in_entry_id       <= id;
    in_entry_priority <= pri;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stop sending until every owed result has come back
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.owed_count() != 0);
  endtask

  // Ids mostly from a small pool so removes find their target
  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(0, 5))
      0, 1:    return ID_W'($urandom());
      2:       return {ID_W{1'b1}};
      default: return ID_W'($urandom_range(0, 11));
    endcase
  endfunction

  // Priorities with frequent ties and extremes
  function automatic logic [PRI_W-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0:       return PRI_W'($urandom());
      1:       return $urandom_range(0, 1) ? {PRI_W{1'b1}} : '0;
      default: return PRI_W'($urandom_range(0, 5) * 51);
    endcase
  endfunction

  task automatic send_random(req_mix_t mix);
    int               roll;
    int               insert_pct;
    int               pop_pct;
    logic [CMD_W-1:0] cmd;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin insert_pct = 70; pop_pct = 10; end
      MIX_DRAIN: begin insert_pct = 15; pop_pct = 40; end
      default:   begin insert_pct = 40; pop_pct = 20; end
    endcase
    if (roll < insert_pct)                cmd = CMD_INSERT;
    else if (roll < insert_pct + pop_pct) cmd = CMD_POP;
    else if (roll % 2 == 0)               cmd = CMD_ROTATE;
    else                                  cmd = CMD_REMOVE;
    send_request(cmd, pick_id(), pick_priority());
  endtask

  initial begin
    int       sent;
    int       burst;
    bit       drained_once;
    req_mix_t mix;
    sb                = new();
    quiet_cycles      = 0;
    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_cmd            <= CMD_INSERT;
    in_entry_id       <= '0;
    in_entry_priority <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-queue cases, one-entry rotate, every placement rule
    send_request(CMD_POP, 16'h0000, 8'h00);
    send_request(CMD_ROTATE, 16'hFFFF, 8'hFF);
    send_request(CMD_REMOVE, 16'h0000, 8'h00);
    send_request(CMD_INSERT, 16'h0000, 8'h00);
    send_request(CMD_ROTATE, 16'h0000, 8'h00);
    send_request(CMD_INSERT, 16'hFFFF, 8'hFF);
    send_request(CMD_INSERT, 16'h1234, 8'h00);
    send_request(CMD_INSERT, 16'h5555, 8'h80);
    send_request(CMD_INSERT, 16'hAAAA, 8'h80);
    send_request(CMD_INSERT, 16'h0001, 8'hFF);
    send_request(CMD_INSERT, 16'h0002, 8'h01);
    send_request(CMD_ROTATE, 16'h0000, 8'h00);
    send_request(CMD_REMOVE, 16'h5555, 8'hFF);
    send_request(CMD_REMOVE, 16'h7777, 8'h00);
    send_request(CMD_REMOVE, 16'hFFFF, 8'h00);
    send_request(CMD_POP, 16'hFFFF, 8'hFF);
    // Four entries left: fill to the top, then one refused insert
    for (int k = 0; k < QDEPTH - 3; k++)
      send_request(CMD_INSERT, ID_W'(16'h0100 + k), PRI_W'(k * 17));
    pause($urandom_range(1, 6));

    // Random bursts with gaps; one full drain part way through
    sent         = 0;
    drained_once = 1'b0;
    mix          = MIX_EVEN;
    while (sent < NUM_RANDOM_REQS) begin
      if ($urandom_range(0, 2) == 0) mix = req_mix_t'($urandom_range(0, 2));
      burst = $urandom_range(1, 16);
      repeat (burst) send_random(mix);
      sent += burst;
      if (!drained_once && sent >= NUM_RANDOM_REQS / 2) begin
        drained_once = 1'b1;
        wait_for_drain();
      end else begin
        pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.owed_count() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
